/* design/assert_macros.svh */
// Assertion macros shared by the framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// Check that cond implies expr in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("assertion failed");

// Check that cond implies expr in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* design/apf_pkg.sv */
// Types, constants and the type table of the packet framer.
package apf_pkg;

    localparam int BUFFER_DEPTH_DEF = 20;
    localparam int MAX_RESULTS      = 20;
    localparam int POS_W            = 5;
    localparam int TICK_W           = 16;
    localparam int NUM_TYPES        = 7;
    localparam int LEN_W            = 8;

    localparam logic [7:0]        SYNC_BYTE       = 8'h21;
    localparam logic [7:0]        CHECK_INIT      = 8'hFF;
    localparam logic [LEN_W-1:0]  MIN_TYPED_LEN   = 8'd5;
    localparam logic [2:0]        FREEFORM_KIND   = 3'd7;
    localparam logic [TICK_W-1:0] TIMEOUT_DEF     = 16'd500;
    localparam logic [TICK_W-1:0] TICK_MAX        = 16'hFFFF;

    localparam logic             KIND_BYTE = 1'b0;
    localparam logic             KIND_TICK = 1'b1;

    localparam logic [7:0]       TYPE_IDS  [NUM_TYPES] =
        '{8'h41, 8'h47, 8'h4D, 8'h51, 8'h42, 8'h43, 8'h4C};
    localparam logic [LEN_W-1:0] TYPE_LENS [NUM_TYPES] =
        '{8'd15, 8'd15, 8'd15, 8'd19, 8'd5, 8'd6, 8'd15};

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [POS_W-1:0] byte_position;
        logic [2:0]       packet_kind;
        logic             status;
        logic [POS_W-1:0] frame_length;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic             err;
        logic [2:0]       kind;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] count;
    } t_emit_req;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_type_hit;

    function automatic t_type_hit type_lookup(input logic [7:0] id,
                                              input logic [LEN_W-1:0] len);
        t_type_hit res;
        res = '0;
        for (int t = NUM_TYPES - 1; t >= 0; t--) begin
            if (id == TYPE_IDS[t] && len == TYPE_LENS[t]) begin
                res.hit = 1'b1;
                res.idx = 3'(t);
            end
        end
        return res;
    endfunction

endpackage

/* design/app_packet_framer_with_checksum_core.sv */
// Top level of the sync-byte packet framer with checksum.
// A frame-ending item starts the output through the FETCH and SEND states; an error result skips FETCH.
// Throughput: 1 input item per cycle while no frame is being sent; input is blocked while a frame
// is sent, one result per cycle through the store's read port while the output is ready.
// Reset (i_rst_n, synchronous, active low): empty frame, check 255, timeout 500 ticks.
`include "assert_macros.svh"

module app_packet_framer_with_checksum_core #(
    parameter int BUFFER_DEPTH = apf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  apf_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output apf_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_we,
    input  logic [apf_pkg::TICK_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic               accept;
    logic               busy;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [7:0]         rdata;
    apf_pkg::t_emit_req req;

    assign o_in_ready = !busy;
    assign accept     = i_in_valid && o_in_ready;

    apf_ingest #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ingest (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_req       (req)
    );

    apf_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    apf_emit #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_busy  (busy),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    `ASSERT_NEXT(a_start_blocks_input, i_clk, i_rst_n, req.start, !o_in_ready)
    `ASSERT_IMPLIES(a_no_write_while_sending, i_clk, i_rst_n, re, !we)

endmodule

/* design/apf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/apf_ingest.sv */
// Input side: stores bytes, tracks checksum and idle ticks, decides frame end.
`include "assert_macros.svh"

module apf_ingest #(
    parameter int BUFFER_DEPTH = apf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  apf_pkg::t_in_item               i_item,
    input  logic                            i_cfg_we,
    input  logic [apf_pkg::TICK_W-1:0]      i_cfg_wdata,
    output logic                            o_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_waddr,
    output logic [7:0]                      o_wdata,
    output apf_pkg::t_emit_req              o_req
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [CW-1:0]              r_count;
    logic [7:0]                 r_check;
    logic [apf_pkg::TICK_W-1:0] r_idle;
    logic [apf_pkg::TICK_W-1:0] r_timeout;
    logic                       r_sync0;
    logic [7:0]                 r_byte1;

    logic                       is_byte;
    logic                       is_sync;
    logic [CW-1:0]              base;
    logic [CW-1:0]              n_count;
    logic [7:0]                 chk_base;
    logic                       n_sync0;
    logic [7:0]                 n_byte1;
    logic                       full;
    apf_pkg::t_type_hit         hit;
    logic                       typed;
    logic [apf_pkg::TICK_W-1:0] n_idle;
    logic                       timed_out;
    logic                       byte_end;
    logic                       tick_end;

    function automatic logic [apf_pkg::POS_W-1:0] run_len(input logic [CW-1:0] cnt);
        if (cnt >= CW'(apf_pkg::MAX_RESULTS)) begin
            return apf_pkg::POS_W'(apf_pkg::MAX_RESULTS);
        end
        return cnt[apf_pkg::POS_W-1:0];
    endfunction

    always_comb begin
        is_byte  = (i_item.kind == apf_pkg::KIND_BYTE);
        is_sync  = (i_item.rx_byte == apf_pkg::SYNC_BYTE);
        base     = is_sync ? '0 : r_count;
        if (base >= CW'(BUFFER_DEPTH)) begin
            base = '0;
        end
        n_count  = base + CW'(1);
        chk_base = is_sync ? apf_pkg::CHECK_INIT : r_check;
        n_sync0  = (base == CW'(0)) ? is_sync : r_sync0;
        n_byte1  = (base == CW'(1)) ? i_item.rx_byte : r_byte1;
        full     = (n_count >= CW'(BUFFER_DEPTH));
        hit      = apf_pkg::type_lookup(n_byte1, apf_pkg::LEN_W'(n_count));
        typed    = (apf_pkg::LEN_W'(n_count) >= apf_pkg::MIN_TYPED_LEN) && n_sync0 && hit.hit;

        n_idle    = (r_idle == apf_pkg::TICK_MAX) ? r_idle : r_idle + 1'b1;
        timed_out = (n_idle >= r_timeout);

        byte_end = i_accept && is_byte && (full || typed);
        tick_end = i_accept && !is_byte && timed_out;

        o_we    = i_accept && is_byte;
        o_waddr = base[AW-1:0];
        o_wdata = i_item.rx_byte;

        o_req = '0;
        if (byte_end) begin
            o_req.start = 1'b1;
            if (full) begin
                o_req.kind  = apf_pkg::FREEFORM_KIND;
                o_req.len   = n_count[apf_pkg::POS_W-1:0];
                o_req.count = run_len(n_count);
            end else if (chk_base != i_item.rx_byte) begin
                o_req.err   = 1'b1;
                o_req.kind  = hit.idx;
                o_req.count = apf_pkg::POS_W'(1);
            end else begin
                o_req.kind  = hit.idx;
                o_req.len   = n_count[apf_pkg::POS_W-1:0];
                o_req.count = run_len(n_count);
            end
        end else if (tick_end && r_count != '0) begin
            o_req.start = 1'b1;
            o_req.kind  = apf_pkg::FREEFORM_KIND;
            o_req.len   = r_count[apf_pkg::POS_W-1:0];
            o_req.count = run_len(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_check   <= apf_pkg::CHECK_INIT;
            r_idle    <= '0;
            r_timeout <= apf_pkg::TIMEOUT_DEF;
            r_sync0   <= 1'b0;
            r_byte1   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (byte_end || tick_end) begin
                r_count <= '0;
                r_check <= apf_pkg::CHECK_INIT;
                r_idle  <= '0;
            end else if (i_accept && is_byte) begin
                r_count <= n_count;
                r_check <= chk_base - i_item.rx_byte;
                r_idle  <= '0;
                r_sync0 <= n_sync0;
                r_byte1 <= n_byte1;
            end else if (i_accept) begin
                r_idle <= n_idle;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_below_depth, i_clk, i_rst_n, r_count < CW'(BUFFER_DEPTH))

endmodule

/* design/apf_emit.sv */
// Output side: reads a finished frame from the store and sends it item by item; an error is one item, not read.
`include "assert_macros.svh"

module apf_emit #(
    parameter int BUFFER_DEPTH = apf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  apf_pkg::t_emit_req              i_req,
    output logic                            o_busy,
    output logic                            o_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_raddr,
    input  logic [7:0]                      i_rdata,
    output logic                            o_valid,
    input  logic                            i_ready,
    output apf_pkg::t_out_item              o_item
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEND
    } t_state;

    t_state                      r_state;
    logic [apf_pkg::POS_W-1:0]   r_idx;
    logic [apf_pkg::POS_W-1:0]   r_n;
    logic [apf_pkg::POS_W-1:0]   r_len;
    logic [2:0]                  r_kind;
    logic                        r_err;

    logic                        is_last;
    logic                        advance;

    always_comb begin
        is_last = (r_idx + 1'b1 == r_n);
        advance = (r_state == S_SEND) && i_ready && !is_last;
        o_busy  = (r_state != S_IDLE);
        o_valid = (r_state == S_SEND);
        o_re    = (r_state == S_FETCH) || advance;
        o_raddr = advance ? AW'(r_idx + 1'b1) : AW'(r_idx);

        o_item.out_byte      = r_err ? 8'd0 : i_rdata;
        o_item.byte_position = r_idx;
        o_item.packet_kind   = r_kind;
        o_item.status        = r_err;
        o_item.frame_length  = r_len;
        o_item.last          = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
            r_len   <= '0;
            r_kind  <= '0;
            r_err   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_idx   <= '0;
                        r_n     <= i_req.count;
                        r_len   <= i_req.len;
                        r_kind  <= i_req.kind;
                        r_err   <= i_req.err;
                        r_state <= i_req.err ? S_SEND : S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (i_ready) begin
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_idx_in_run, i_clk, i_rst_n, o_valid, r_idx < r_n)
    `ASSERT_IMPLIES(a_err_single, i_clk, i_rst_n, o_valid && r_err, is_last && r_idx == '0)
    `ASSERT_NEXT(a_advance_holds_send, i_clk, i_rst_n, advance, r_state == S_SEND)

endmodule
